// ===== rtl/core/bsfr_pkg.sv =====
// Shared types and constants for the byte-stuffed frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package bsfr_pkg;

  localparam logic [7:0] EscForStart = 8'hDC;
  localparam logic [7:0] EscForEnd   = 8'hDD;
  localparam logic [7:0] EscForEsc   = 8'hDE;

  localparam logic [7:0] StartCodeRst  = 8'hC0;
  localparam logic [7:0] EndCodeRst    = 8'hC1;
  localparam logic [7:0] EscapeCodeRst = 8'hDB;

  typedef enum logic [1:0] {
    CFG_START_CODE  = 2'd0,
    CFG_END_CODE    = 2'd1,
    CFG_ESCAPE_CODE = 2'd2,
    CFG_NONE        = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_LEN_HI   = 3'd1,
    PH_LEN_LO   = 3'd2,
    PH_PAYLOAD  = 3'd3,
    PH_CHECK    = 3'd4,
    PH_WAIT_END = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_FRAME_OK  = 2'd1,
    KIND_SUM_ERROR = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] start_code;
    logic [7:0] end_code;
    logic [7:0] escape_code;
  } codes_t;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic [15:0] frame_length;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/bsfr_core.sv =====
// Frame state machine that decodes one received byte per step.
`timescale 1ns / 1ps
`default_nettype none

module bsfr_core
  import bsfr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  input  wire codes_t     codes_i,
  output result_t         result_o
);

  phase_e      phase_q, phase_d;
  logic        esc_q, esc_d;
  logic [15:0] len_q, len_d;
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  sum_q, sum_d;

  logic        is_start, is_end, is_esc;
  logic [7:0]  data_byte;
  logic [15:0] cnt_inc;
  logic [7:0]  sum_inc;

  assign is_start = (byte_i == codes_i.start_code);
  assign is_end   = !is_start && (byte_i == codes_i.end_code);
  assign is_esc   = !is_start && !is_end && (byte_i == codes_i.escape_code);
  assign cnt_inc  = cnt_q + 16'd1;
  assign sum_inc  = sum_q + data_byte;

  always_comb begin
    data_byte = byte_i;
    if (esc_q) begin
      if (byte_i == EscForStart) begin
        data_byte = codes_i.start_code;
      end else if (byte_i == EscForEnd) begin
        data_byte = codes_i.end_code;
      end else if (byte_i == EscForEsc) begin
        data_byte = codes_i.escape_code;
      end
    end
  end

  always_comb begin
    phase_d = phase_q;
    esc_d   = esc_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    if (is_start) begin
      phase_d = PH_LEN_HI;
      esc_d   = 1'b0;
    end else if (is_end) begin
      if (phase_q == PH_WAIT_END) begin
        phase_d = PH_IDLE;
      end
    end else if (is_esc) begin
      esc_d = 1'b1;
    end else begin
      esc_d = 1'b0;
      unique case (phase_q)
        PH_LEN_HI: begin
          len_d   = {data_byte, 8'd0};
          phase_d = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_d   = {len_q[15:8], data_byte};
          cnt_d   = '0;
          sum_d   = '0;
          phase_d = ({len_q[15:8], data_byte} == 16'd0) ? PH_CHECK : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          sum_d = sum_inc;
          cnt_d = cnt_inc;
          if (cnt_inc == len_q) begin
            phase_d = PH_CHECK;
          end
        end
        PH_CHECK: begin
          phase_d = (sum_q == data_byte) ? PH_WAIT_END : PH_IDLE;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    result_o.valid        = 1'b0;
    result_o.kind         = KIND_PAYLOAD;
    result_o.payload_byte = 8'd0;
    result_o.frame_length = len_q;
    if (is_end) begin
      if (phase_q == PH_WAIT_END) begin
        result_o.valid = 1'b1;
        result_o.kind  = KIND_FRAME_OK;
      end
    end else if (!is_start && !is_esc) begin
      if (phase_q == PH_PAYLOAD) begin
        result_o.valid        = 1'b1;
        result_o.payload_byte = data_byte;
      end else if (phase_q == PH_CHECK && sum_q != data_byte) begin
        result_o.valid = 1'b1;
        result_o.kind  = KIND_SUM_ERROR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      esc_q   <= 1'b0;
      len_q   <= '0;
      cnt_q   <= '0;
      sum_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      esc_q   <= esc_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
    end
  end

  a_start_opens_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && is_start |=> phase_q == PH_LEN_HI && !esc_q)
    else $error("start code did not open a frame");

  a_count_below_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> cnt_q < len_q)
    else $error("payload count reached declared length without leaving payload");

  a_good_only_after_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.kind == KIND_FRAME_OK |-> phase_q == PH_WAIT_END)
    else $error("frame good reported outside the wait for end");

  a_payload_advances_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && result_o.valid && result_o.kind == KIND_PAYLOAD |=> cnt_q == $past(cnt_inc))
    else $error("payload transaction did not advance the byte count");

endmodule

`default_nettype wire

// ===== rtl/core/byte_stuffed_frame_receiver.sv =====
// Top level of the byte-stuffed frame receiver with input and result registers.
// The receiver takes one byte transaction per clock cycle while rx_stall_o is low, and a byte's result
// passes from acceptance through the input register, where the frame state machine decodes the
// byte, and then the result register. A result that is held by out_stall_i stops the
// input register only when the byte behind it would also produce a result, so bytes that
// produce nothing keep flowing. Configuration writes take effect on the next cycle and are
// meant to happen while no transaction is in flight.
`timescale 1ns / 1ps
`default_nettype none

module byte_stuffed_frame_receiver
  import bsfr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        rx_valid_i,
  output logic             rx_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       payload_byte_o,
  output logic [15:0]      frame_length_o
);

  codes_t      codes_q;
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        out_valid_q;
  result_t     out_q;
  result_t     core_res;
  logic        advance;
  logic        rx_accept;
  cfg_idx_e    cfg_idx;

  assign cfg_idx = cfg_idx_e'(cfg_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q.start_code  <= StartCodeRst;
      codes_q.end_code    <= EndCodeRst;
      codes_q.escape_code <= EscapeCodeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx)
        CFG_START_CODE:  codes_q.start_code  <= cfg_data_i;
        CFG_END_CODE:    codes_q.end_code    <= cfg_data_i;
        CFG_ESCAPE_CODE: codes_q.escape_code <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  bsfr_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .codes_i  (codes_q),
    .result_o (core_res)
  );

  assign advance    = in_valid_q && (!core_res.valid || !out_valid_q || !out_stall_i);
  assign rx_stall_o = in_valid_q && !advance;
  assign rx_accept  = rx_valid_i && !rx_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_accept) begin
      in_byte_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && core_res.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && core_res.valid) begin
      out_q <= core_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_q.kind;
  assign payload_byte_o = out_q.payload_byte;
  assign frame_length_o = out_q.frame_length;

endmodule

`default_nettype wire

// ===== tb/byte_stuffed_frame_receiver_test.sv =====
// Self-checking testbench for the byte-stuffed frame receiver with its own deframing predictor.
`timescale 1ns / 1ps

module byte_stuffed_frame_receiver_test;
  import bsfr_pkg::*;

  typedef struct {
    kind_e       kind;
    logic [7:0]  data;
    logic [15:0] length;
  } frame_event_t;

  typedef enum {
    FR_GOOD,
    FR_BAD_SUM,
    FR_TRUNCATED,
    FR_NO_END,
    FR_STRAY_END
  } frame_flavor_e;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  cfg_idx_e    cfg_idx_i;
  logic [7:0]  cfg_data_i;
  logic        rx_valid_i;
  logic        rx_stall_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  kind_o;
  logic [7:0]  payload_byte_o;
  logic [15:0] frame_length_o;

  codes_t       codes;
  phase_e       rx_phase;
  logic         esc_pending;
  logic [15:0]  decl_len;
  logic [15:0]  got_count;
  logic [7:0]   sum_acc;
  frame_event_t pending_events[$];

  int failures;
  int bytes_sent;
  int burst_left;
  int hold_off_left;
  int stall_mode;
  int stall_cycle;

  byte_stuffed_frame_receiver dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .rx_valid_i     (rx_valid_i),
    .rx_stall_o     (rx_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .payload_byte_o (payload_byte_o),
    .frame_length_o (frame_length_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void note_failure(string msg);
    failures++;
    if (failures <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function automatic void push_event(kind_e kind, logic [7:0] data);
    frame_event_t ev;
    ev.kind = kind;
    ev.data = data;
    ev.length = decl_len;
    pending_events.push_back(ev);
  endfunction

  function automatic void deframe_byte(logic [7:0] raw);
    logic [7:0] b;
    b = raw;
    if (raw == codes.start_code) begin
      rx_phase = PH_LEN_HI;
      esc_pending = 1'b0;
    end else if (raw == codes.end_code) begin
      if (rx_phase == PH_WAIT_END) begin
        rx_phase = PH_IDLE;
        push_event(KIND_FRAME_OK, 8'h00);
      end
    end else if (raw == codes.escape_code) begin
      esc_pending = 1'b1;
    end else begin
      if (esc_pending) begin
        if (raw == EscForStart) b = codes.start_code;
        else if (raw == EscForEnd) b = codes.end_code;
        else if (raw == EscForEsc) b = codes.escape_code;
        esc_pending = 1'b0;
      end
      case (rx_phase)
        PH_LEN_HI: begin
          decl_len = {b, 8'h00};
          rx_phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          decl_len = {decl_len[15:8], b};
          got_count = '0;
          sum_acc = '0;
          rx_phase = (decl_len == 16'd0) ? PH_CHECK : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          sum_acc = sum_acc + b;
          got_count = got_count + 16'd1;
          if (got_count == decl_len) rx_phase = PH_CHECK;
          push_event(KIND_PAYLOAD, b);
        end
        PH_CHECK: begin
          if (sum_acc == b) begin
            rx_phase = PH_WAIT_END;
          end else begin
            rx_phase = PH_IDLE;
            push_event(KIND_SUM_ERROR, 8'h00);
          end
        end
        default: begin
        end
      endcase
    end
  endfunction

  always @(posedge clk_i) begin
    frame_event_t ev;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_events.size() == 0) begin
        note_failure($sformatf("Unexpected result: kind %0d byte %02h length %0d",
                               kind_o, payload_byte_o, frame_length_o));
      end else begin
        ev = pending_events.pop_front();
        if (kind_o !== ev.kind || payload_byte_o !== ev.data
            || frame_length_o !== ev.length) begin
          note_failure($sformatf(
              "Mismatch: expected kind %0d byte %02h length %0d, got kind %0d byte %02h length %0d",
              ev.kind, ev.data, ev.length, kind_o, payload_byte_o, frame_length_o));
        end
      end
    end
  end

  // The result side stalls on a pattern that changes every so often; a long
  // hold-off requested by a test takes precedence.
  always @(negedge clk_i) begin
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_stall_i <= 1'b1;
    end else begin
      stall_cycle++;
      if (stall_cycle % 97 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= 1'($urandom_range(0, 1));
        2: out_stall_i <= ($urandom_range(0, 7) == 0);
        default: out_stall_i <= ((stall_cycle % 5) < 2);
      endcase
    end
  end

  task automatic send_byte(logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        rx_valid_i <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    rx_valid_i <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (rx_stall_o);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_results_drained();
    @(negedge clk_i);
    rx_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_code(cfg_idx_e idx, logic [7:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_START_CODE: codes.start_code = value;
      CFG_END_CODE: codes.end_code = value;
      CFG_ESCAPE_CODE: codes.escape_code = value;
      default: begin
      end
    endcase
  endtask

  task automatic set_codes(logic [7:0] start_v, logic [7:0] end_v, logic [7:0] esc_v);
    wait_results_drained();
    write_code(CFG_START_CODE, start_v);
    write_code(CFG_END_CODE, end_v);
    write_code(CFG_ESCAPE_CODE, esc_v);
  endtask

  function automatic logic [7:0] pick_payload();
    case ($urandom_range(0, 11))
      0: return codes.start_code;
      1: return codes.end_code;
      2: return codes.escape_code;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_escaped(logic [7:0] b, bit force_esc);
    if (b == codes.start_code) begin
      send_byte(codes.escape_code);
      send_byte(EscForStart);
    end else if (b == codes.end_code) begin
      send_byte(codes.escape_code);
      send_byte(EscForEnd);
    end else if (b == codes.escape_code) begin
      send_byte(codes.escape_code);
      send_byte(EscForEsc);
    end else if (force_esc && !(b inside {EscForStart, EscForEnd, EscForEsc})) begin
      send_byte(codes.escape_code);
      send_byte(b);
    end else begin
      send_byte(b);
    end
  endtask

  task automatic send_frame(int len, frame_flavor_e flavor);
    logic [15:0] length;
    logic [7:0]  sum;
    logic [7:0]  b;
    int          cut;
    length = 16'(len);
    sum = '0;
    cut = (flavor == FR_TRUNCATED) ? $urandom_range(0, len) : len + 1;
    send_byte(codes.start_code);
    if (flavor == FR_TRUNCATED && $urandom_range(0, 3) == 0) begin
      if ($urandom_range(0, 1) == 1) send_escaped(length[15:8], 1'b0);
      return;
    end
    send_escaped(length[15:8], $urandom_range(0, 7) == 0);
    send_escaped(length[7:0], $urandom_range(0, 7) == 0);
    for (int i = 0; i < len; i++) begin
      if (i == cut) return;
      b = pick_payload();
      sum = sum + b;
      send_escaped(b, $urandom_range(0, 7) == 0);
      if (flavor == FR_STRAY_END && $urandom_range(0, 3) == 0) send_byte(codes.end_code);
    end
    if (flavor == FR_TRUNCATED) return;
    if (flavor == FR_BAD_SUM) sum = sum + 8'($urandom_range(1, 255));
    send_escaped(sum, $urandom_range(0, 7) == 0);
    if (flavor != FR_NO_END) send_byte(codes.end_code);
  endtask

  task automatic test_directed_frames();
    logic [7:0] seq[$];
    seq = '{8'hC0, 8'h00, 8'h00, 8'h00, 8'hC1,
            8'hC0, 8'h00, 8'h03, 8'hDB, 8'hDC, 8'hDB, 8'hDD, 8'hDB, 8'hDE, 8'h5C, 8'hC1,
            8'hC0, 8'hFF, 8'hFF, 8'h7F, 8'h80, 8'hC0, 8'h00, 8'h01, 8'hFF, 8'h00};
    foreach (seq[i]) send_byte(seq[i]);
    wait_results_drained();
  endtask

  task automatic test_long_frame();
    send_frame(300, FR_GOOD);
    wait_results_drained();
  endtask

  task automatic test_backpressure();
    hold_off_left = 150;
    send_frame(48, FR_GOOD);
    wait_results_drained();
    send_frame(6, FR_GOOD);
    wait_results_drained();
  endtask

  task automatic test_random_traffic(int item_budget);
    int            stop_at;
    int            r;
    int            len;
    frame_flavor_e flavor;
    stop_at = bytes_sent + item_budget;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(0, 99);
      len = (r < 85) ? $urandom_range(0, 10) : (r < 99) ? $urandom_range(11, 40)
                                                         : $urandom_range(200, 260);
      r = $urandom_range(0, 99);
      flavor = (r < 65) ? FR_GOOD : (r < 77) ? FR_BAD_SUM : (r < 87) ? FR_TRUNCATED
             : (r < 94) ? FR_NO_END : FR_STRAY_END;
      send_frame(len, flavor);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end
    end
    wait_results_drained();
  endtask

  task automatic test_code_extremes();
    set_codes(8'h00, 8'hFF, 8'h80);
    test_random_traffic(250);
    set_codes(8'hFF, 8'h00, 8'h01);
    test_random_traffic(250);
  endtask

  task automatic test_random_codes();
    logic [7:0] s;
    logic [7:0] e;
    logic [7:0] x;
    do s = 8'($urandom_range(0, 255)); while (s inside {EscForStart, EscForEnd, EscForEsc});
    do e = 8'($urandom_range(0, 255));
    while (e == s || e inside {EscForStart, EscForEnd, EscForEsc});
    do x = 8'($urandom_range(0, 255));
    while (x == s || x == e || x inside {EscForStart, EscForEnd, EscForEsc});
    set_codes(s, e, x);
    test_random_traffic(200);
  endtask

  task automatic test_overlapping_codes();
    set_codes(EscForEnd, EscForStart, EscForEsc);
    repeat (120) begin
      case ($urandom_range(0, 7))
        0: send_byte(EscForStart);
        1: send_byte(EscForEnd);
        2: send_byte(EscForEsc);
        3: send_byte(8'h00);
        default: send_byte(8'($urandom_range(0, 255)));
      endcase
    end
    wait_results_drained();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_START_CODE;
    cfg_data_i = '0;
    rx_valid_i = 1'b0;
    rx_byte_i = '0;
    out_stall_i = 1'b0;
    codes = '{start_code: StartCodeRst, end_code: EndCodeRst, escape_code: EscapeCodeRst};
    rx_phase = PH_IDLE;
    esc_pending = 1'b0;
    decl_len = '0;
    got_count = '0;
    sum_acc = '0;
    failures = 0;
    bytes_sent = 0;
    burst_left = 0;
    hold_off_left = 0;
    stall_mode = 0;
    stall_cycle = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_frames();
    test_long_frame();
    test_backpressure();
    test_random_traffic(100);
    test_code_extremes();
    test_random_codes();
    test_overlapping_codes();
    set_codes(StartCodeRst, EndCodeRst, EscapeCodeRst);
    test_random_traffic(100);

    wait_results_drained();
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
